>>> hw/rtl/ptm_pkg.sv
// ----------------------------------------------------------------------------
// Precursor tolerance matcher package
// Shared sizes, function codes, payload structs and pipeline types for the
// reference table matcher.
// ----------------------------------------------------------------------------
package ptm_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths.
    localparam int FUNC_W  = 3;
    localparam int SCAN_W  = 24;
    localparam int MZ_W    = 32;
    localparam int CHG_W   = 8;
    localparam int TOTAL_W = 11;
    localparam int TOL_W   = 23;
    localparam int START_W = 11;
    localparam int PROD_W  = MZ_W + TOL_W;
    localparam int ISSUE_W = (CNT_W > START_W) ? CNT_W : START_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TOL_W;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX = 1'b1;
    localparam logic [TOL_W-1:0]     TOL_RESET       = 23'd85899;

    // Function codes of an input word.
    localparam logic [FUNC_W-1:0] FUNC_LOAD      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHECK     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TOP_THREE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MONO      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TOP_N     = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_ABANDON   = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR_ALT = 3'd7;

    // Control states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    // Input word.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SCAN_W-1:0] scan_number;
        logic [MZ_W-1:0]   mz_value;
        logic [CHG_W-1:0]  charge_state;
    } in_t;

    // Result word.
    typedef struct packed {
        logic               found;
        logic               status;
        logic [TOTAL_W-1:0] checked_total;
        logic [TOTAL_W-1:0] top_three_total;
        logic [TOTAL_W-1:0] entry_total;
    } out_t;

    // One reference entry as stored in the entry memory.
    typedef struct packed {
        logic [SCAN_W-1:0] scan;
        logic [MZ_W-1:0]   mz;
        logic [CHG_W-1:0]  charge;
    } entry_t;

    // Per-entry flags as stored in the flag memory.
    typedef struct packed {
        logic check;
        logic top_three;
        logic not_in_mono;
        logic not_in_topn;
        logic abandoned;
    } flags_t;

    localparam flags_t LOAD_FLAGS = '{
        check: 1'b0, top_three: 1'b0,
        not_in_mono: 1'b1, not_in_topn: 1'b1, abandoned: 1'b1
    };

    // Outcome of the match pipeline for one entry.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        flags_t            flags;
        logic              match;
    } match_t;

endpackage

>>> hw/rtl/ptm_match_unit.sv
// ----------------------------------------------------------------------------
// Match unit
// Two-stage tolerance test of one stored entry against the query: key
// compare, absolute m/z difference and tolerance product are registered,
// then the scaled difference is compared against the bound.
// ----------------------------------------------------------------------------
module ptm_match_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  logic [ptm_pkg::ADDR_W-1:0] in_addr,
    input  ptm_pkg::entry_t            ref_entry,
    input  ptm_pkg::flags_t            ref_flags,
    input  ptm_pkg::in_t               query,
    input  logic [ptm_pkg::TOL_W-1:0]  tol,
    input  logic                       wide,
    output ptm_pkg::match_t            result
);

    logic                        eq_c;
    logic [ptm_pkg::MZ_W-1:0]    diff_c;
    logic [ptm_pkg::PROD_W-1:0]  prod_c;

    logic                        valid_reg;
    logic [ptm_pkg::ADDR_W-1:0]  addr_reg;
    ptm_pkg::flags_t             flags_reg;
    logic                        eq_reg;
    logic [ptm_pkg::MZ_W-1:0]    diff_reg;
    logic [ptm_pkg::PROD_W-1:0]  prod_reg;
    logic                        wide_reg;

    logic [ptm_pkg::PROD_W:0]    bound;
    logic [ptm_pkg::PROD_W:0]    scaled_diff;

    // Key compare, absolute difference and tolerance product.
    always_comb begin
        eq_c = (ref_entry.scan == query.scan_number) &&
               (ref_entry.charge == query.charge_state);
        if (query.mz_value >= ref_entry.mz) begin
            diff_c = query.mz_value - ref_entry.mz;
        end else begin
            diff_c = ref_entry.mz - query.mz_value;
        end
        prod_c = ptm_pkg::PROD_W'(ref_entry.mz) * ptm_pkg::PROD_W'(tol);
    end

    // Stage register; the valid bit is the only control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg  <= in_addr;
        flags_reg <= ref_flags;
        eq_reg    <= eq_c;
        diff_reg  <= diff_c;
        prod_reg  <= prod_c;
        wide_reg  <= wide;
    end

    // The difference times 2^32 must lie strictly below the bound. A
    // difference of 2^24 or more is already beyond any bound.
    always_comb begin
        bound       = wide_reg ? {prod_reg, 1'b0} : {1'b0, prod_reg};
        scaled_diff = {diff_reg[23:0], 32'd0};
        result.valid = valid_reg;
        result.addr  = addr_reg;
        result.flags = flags_reg;
        result.match = eq_reg && (diff_reg[ptm_pkg::MZ_W-1:24] == '0) &&
                       (scaled_diff < bound);
    end

endmodule

>>> hw/rtl/precursor_tolerance_matcher.sv
// ----------------------------------------------------------------------------
// Precursor tolerance matcher
// Reference table of scan, m/z and charge entries with relative tolerance
// search, per-entry cause flags and running flag counts.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on s_valid/s_ready/s_data and each one produces exactly
// one result word on m_valid/m_ready/m_data. The block handles one word at a
// time; s_ready is high only while it is idle.
// A load word writes the entry memory and flag memory directly, or sets
// status when the table is full; its result is registered in the response
// step. Every other word scans the table through the entry and flag memories,
// one entry per cycle on the single read port; the scan covers all loaded
// entries, or those from start_index up for a top-three word. A single-match
// word (check, mono, top-n, abandon) stops issuing reads after its first hit.
// A clear word sweeps the loaded entries the same way to drop their check
// flags. The table holds up to 1024 entries.
// The result sits in an output register; a stalled receiver holds the block
// in its response step until the previous result is taken, while a new word
// is already accepted as soon as the last result is registered.
// Reset (aresetn low, synchronous) empties the table, clears all counts and
// loads tolerance_fraction 85899 and start_index 0. No clearing pass is needed
// since entries are only read below the entry count.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once.
// ----------------------------------------------------------------------------
module precursor_tolerance_matcher (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ptm_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ptm_pkg::out_t                  m_data,
    input  logic                           cfg_wr_en,
    input  logic [ptm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [ptm_pkg::TOL_W-1:0]   tol_reg;
    logic [ptm_pkg::START_W-1:0] start_reg;

    // Control and counters.
    ptm_pkg::state_t             state_reg, state_next;
    ptm_pkg::in_t                query_reg;
    logic [ptm_pkg::CNT_W-1:0]   entry_count_reg;
    logic [ptm_pkg::CNT_W-1:0]   check_count_reg;
    logic [ptm_pkg::CNT_W-1:0]   top_count_reg;
    logic [ptm_pkg::ISSUE_W-1:0] issue_addr_reg;
    logic                        rd_valid_reg;
    logic [ptm_pkg::ADDR_W-1:0]  rd_addr_reg;
    logic                        hit_reg;
    logic                        found_reg;
    logic                        status_reg;
    logic                        m_valid_reg;
    ptm_pkg::out_t               m_data_reg;

    // Memories and their read data.
    ptm_pkg::entry_t             entry_mem [ptm_pkg::TABLE_DEPTH];
    ptm_pkg::flags_t             flag_mem  [ptm_pkg::TABLE_DEPTH];
    ptm_pkg::entry_t             entry_rd_reg;
    ptm_pkg::flags_t             flag_rd_reg;

    // Combinational control.
    logic                        accept;
    logic                        is_load;
    logic                        load_ok;
    logic                        load_we;
    logic                        scan_busy;
    logic                        out_free;
    logic                        resp_load;
    logic                        issue_en;
    logic                        scan_done;
    logic                        q_clear;
    logic                        q_top_three;
    ptm_pkg::match_t             match;
    ptm_pkg::flags_t             flag_wdata;
    logic                        flag_upd;
    logic                        flag_we;
    logic [ptm_pkg::ADDR_W-1:0]  flag_waddr;
    logic                        chk_inc;
    logic                        top_inc;
    logic                        hit_set;
    logic                        found_set;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg   <= ptm_pkg::TOL_RESET;
            start_reg <= '0;
        end else if (cfg_wr_en) begin
            priority if (cfg_index == ptm_pkg::CFG_TOLERANCE) begin
                tol_reg <= cfg_wdata;
            end else if (cfg_index == ptm_pkg::CFG_START_INDEX) begin
                start_reg <= cfg_wdata[ptm_pkg::START_W-1:0];
            end
        end
    end

    // Word decode.
    assign accept      = s_valid && s_ready;
    assign is_load     = (s_data.func == ptm_pkg::FUNC_LOAD);
    assign load_ok     = (entry_count_reg < ptm_pkg::CNT_W'(ptm_pkg::TABLE_DEPTH));
    assign load_we     = accept && is_load && load_ok;
    assign out_free    = !m_valid_reg || m_ready;
    assign q_clear     = (query_reg.func == ptm_pkg::FUNC_CLEAR) ||
                         (query_reg.func == ptm_pkg::FUNC_CLEAR_ALT);
    assign q_top_three = (query_reg.func == ptm_pkg::FUNC_TOP_THREE);

    // Read issue runs while entries remain and no single match has hit.
    assign issue_en  = scan_busy && !hit_reg &&
                       (issue_addr_reg < ptm_pkg::ISSUE_W'(entry_count_reg));
    assign scan_done = scan_busy && !issue_en && !rd_valid_reg && !match.valid;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = is_load ? ptm_pkg::ST_RESP : ptm_pkg::ST_SCAN;
                end
            end
            ptm_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = ptm_pkg::ST_RESP;
                end
            end
            ptm_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = ptm_pkg::ST_IDLE;
                end
            end
            default: state_next = ptm_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_ready   = 1'b0;
        scan_busy = 1'b0;
        resp_load = 1'b0;
        unique case (state_reg)
            ptm_pkg::ST_IDLE: s_ready   = 1'b1;
            ptm_pkg::ST_SCAN: scan_busy = 1'b1;
            ptm_pkg::ST_RESP: resp_load = out_free;
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Query capture.
    always_ff @(posedge aclk) begin
        if (accept) begin
            query_reg <= s_data;
        end
    end

    // Scan address and read-valid pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_addr_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end else begin
            rd_valid_reg <= issue_en;
            if (accept) begin
                if (s_data.func == ptm_pkg::FUNC_TOP_THREE) begin
                    issue_addr_reg <= ptm_pkg::ISSUE_W'(start_reg);
                end else begin
                    issue_addr_reg <= '0;
                end
            end else if (issue_en) begin
                issue_addr_reg <= issue_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= issue_addr_reg[ptm_pkg::ADDR_W-1:0];
    end

    // Entry memory: written by loads, read once per scanned entry.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            entry_mem[entry_count_reg[ptm_pkg::ADDR_W-1:0]] <=
                '{scan: s_data.scan_number, mz: s_data.mz_value,
                  charge: s_data.charge_state};
        end
        if (issue_en) begin
            entry_rd_reg <= entry_mem[issue_addr_reg[ptm_pkg::ADDR_W-1:0]];
        end
    end

    // Flag memory: written by loads, read alongside the entry, written back after the test.
    always_ff @(posedge aclk) begin
        if (flag_we) begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        if (issue_en) begin
            flag_rd_reg <= flag_mem[issue_addr_reg[ptm_pkg::ADDR_W-1:0]];
        end
    end

    ptm_match_unit u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid_reg),
        .in_addr   (rd_addr_reg),
        .ref_entry (entry_rd_reg),
        .ref_flags (flag_rd_reg),
        .query     (query_reg),
        .tol       (tol_reg),
        .wide      (q_top_three),
        .result    (match)
    );

    // Flag update for the entry leaving the match unit. Each entry passes
    // once per scan, so the write-back never races a read of the same entry.
    always_comb begin
        flag_wdata = match.flags;
        flag_upd   = 1'b0;
        chk_inc    = 1'b0;
        top_inc    = 1'b0;
        hit_set    = 1'b0;
        found_set  = 1'b0;
        if (match.valid) begin
            if (q_clear) begin
                flag_wdata.check = 1'b0;
                flag_upd         = 1'b1;
            end else if (q_top_three) begin
                if (match.match) begin
                    found_set = 1'b1;
                    if (!match.flags.top_three) begin
                        flag_wdata.top_three = 1'b1;
                        flag_upd             = 1'b1;
                        top_inc              = 1'b1;
                    end
                end
            end else if (match.match && !hit_reg) begin
                hit_set   = 1'b1;
                found_set = 1'b1;
                flag_upd  = 1'b1;
                unique case (query_reg.func)
                    ptm_pkg::FUNC_CHECK: begin
                        flag_wdata.check = 1'b1;
                        chk_inc          = !match.flags.check;
                    end
                    ptm_pkg::FUNC_MONO:  flag_wdata.not_in_mono = 1'b0;
                    ptm_pkg::FUNC_TOP_N: flag_wdata.not_in_topn = 1'b0;
                    default:             flag_wdata.abandoned   = 1'b0;
                endcase
            end
        end
        // A load writes its fresh flags; it never overlaps a scan.
        flag_we    = flag_upd;
        flag_waddr = match.addr;
        if (load_we) begin
            flag_we    = 1'b1;
            flag_waddr = entry_count_reg[ptm_pkg::ADDR_W-1:0];
            flag_wdata = ptm_pkg::LOAD_FLAGS;
        end
    end

    // Counters and per-word status.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            check_count_reg <= '0;
            top_count_reg   <= '0;
            hit_reg         <= 1'b0;
            found_reg       <= 1'b0;
            status_reg      <= 1'b0;
        end else begin
            if (load_we) begin
                entry_count_reg <= entry_count_reg + 1'b1;
            end
            if (accept) begin
                hit_reg    <= 1'b0;
                found_reg  <= 1'b0;
                status_reg <= is_load && !load_ok;
                if ((s_data.func == ptm_pkg::FUNC_CLEAR) ||
                    (s_data.func == ptm_pkg::FUNC_CLEAR_ALT)) begin
                    check_count_reg <= '0;
                end
            end else begin
                if (hit_set) begin
                    hit_reg <= 1'b1;
                end
                if (found_set) begin
                    found_reg <= 1'b1;
                end
                if (chk_inc) begin
                    check_count_reg <= check_count_reg + 1'b1;
                end
                if (top_inc) begin
                    top_count_reg <= top_count_reg + 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (resp_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (resp_load) begin
            m_data_reg.found           <= found_reg;
            m_data_reg.status          <= status_reg;
            m_data_reg.checked_total   <= ptm_pkg::TOTAL_W'(check_count_reg);
            m_data_reg.top_three_total <= ptm_pkg::TOTAL_W'(top_count_reg);
            m_data_reg.entry_total     <= ptm_pkg::TOTAL_W'(entry_count_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
